@@ rtl/g2c_pkg.sv @@
// shared types, constants and elaboration-time tables for the geodetic to cartesian converter
package g2c_pkg;

    // default rotation count of the sine and cosine engines
    localparam int CORDIC_STEPS_DEF = 32;
    // register stages inside one multiplier
    localparam int MUL_LAT = 4;
    // one root bit per stage
    localparam int SQRT_STEPS = 64;
    // one quotient bit per stage, radius is clamped at 2^62
    localparam int DIV_STEPS = 62;

    // configuration register indexes
    localparam logic CFG_AXIS = 1'b0;
    localparam logic CFG_ECC = 1'b1;

    typedef logic signed [63:0] t_q60;

    // sines and cosines of latitude and longitude traveling down the pipe
    typedef struct packed {
        t_q60 s1;
        t_q60 c1;
        t_q60 s2;
        t_q60 c2;
    } t_trig;

    localparam t_q60 ONE_Q60 = 64'sh1000_0000_0000_0000;
    localparam t_q60 PI_Q60 = 64'sh3243_F6A8_885A_308D;
    localparam t_q60 RADIUS_MAX = 64'sh4000_0000_0000_0000;
    localparam logic [33:0] AXIS_RST = 34'd6378137000;
    localparam logic [39:0] ECC_RST = 40'd7360548640;
    localparam logic [33:0] OUT_LIMIT = 34'd8000000000;
    // smallest q8 magnitude that rounds above the output limit
    localparam logic [63:0] SAT_EDGE = 64'd2048000000128;

    // shift-subtract division, used only for constants
    function automatic logic [127:0] f_udiv128(input logic [127:0] num, input logic [127:0] den);
        logic [128:0] rem;
        logic [127:0] q;
        rem = '0;
        q = '0;
        for (int b = 127; b >= 0; b--) begin
            rem = {rem[127:0], num[b]};
            q = {q[126:0], 1'b0};
            if (rem >= {1'b0, den}) begin
                rem = rem - {1'b0, den};
                q[0] = 1'b1;
            end
        end
        return q;
    endfunction

    // atan(2^-i) in q60, taylor series with truncated terms
    function automatic t_q60 f_atan(input int i);
        t_q60 sum;
        logic [127:0] term;
        int e;
        sum = '0;
        if (i == 0) begin
            sum = PI_Q60 >>> 2;
        end else begin
            for (int k = 0; k < 31; k++) begin
                e = 60 - i * (2 * k + 1);
                if (e >= 0) begin
                    term = f_udiv128(128'(1) << e, 128'(2 * k + 1));
                    if (k % 2 == 1)
                        sum = sum - $signed(term[63:0]);
                    else
                        sum = sum + $signed(term[63:0]);
                end
            end
        end
        return sum;
    endfunction

    // inverse rotation gain in q60 for a given step count
    function automatic t_q60 f_gain(input int steps);
        logic [127:0] p;
        logic [127:0] v;
        logic [129:0] rem;
        logic [129:0] rs;
        logic [129:0] trial;
        logic [63:0] root;
        logic [127:0] q;
        p = 128'(1) << 60;
        for (int i = 0; i < steps; i++) begin
            if (2 * i < 64)
                p = p + (p >> (2 * i));
        end
        v = p << 60;
        rem = '0;
        root = '0;
        for (int k = 0; k < 64; k++) begin
            rs = {rem[127:0], v[127 - 2 * k], v[126 - 2 * k]};
            trial = {64'b0, root, 2'b01};
            if (rs >= trial) begin
                rem = rs - trial;
                root = {root[62:0], 1'b1};
            end else begin
                rem = rs;
                root = {root[62:0], 1'b0};
            end
        end
        q = f_udiv128(128'(1) << 120, {64'b0, root});
        return $signed(q[63:0]);
    endfunction

endpackage

@@ rtl/g2c_mul.sv @@
// pipelined signed 64x64 multiply, shift right toward zero, saturate to 63 bits
module g2c_mul #(
    parameter int SH = 60
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  g2c_pkg::t_q60 i_a,
    input  g2c_pkg::t_q60 i_b,
    output g2c_pkg::t_q60 o_p
);
    import g2c_pkg::*;

    logic         r_neg1, r_neg2, r_neg3;
    logic [63:0]  r_ua, r_ub;
    logic [63:0]  r_pp [0:3];
    logic [127:0] r_prod;
    t_q60         r_p;
    logic         w_sat;
    logic [63:0]  w_val;

    // sign and magnitudes
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_neg1 <= i_a[63] ^ i_b[63];
            r_ua <= i_a[63] ? 64'(-i_a) : 64'(i_a);
            r_ub <= i_b[63] ? 64'(-i_b) : 64'(i_b);
        end
    end

    // 32x32 partial products
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_neg2 <= r_neg1;
            r_pp[0] <= r_ua[31:0] * r_ub[31:0];
            r_pp[1] <= r_ua[31:0] * r_ub[63:32];
            r_pp[2] <= r_ua[63:32] * r_ub[31:0];
            r_pp[3] <= r_ua[63:32] * r_ub[63:32];
        end
    end

    // full product
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_neg3 <= r_neg2;
            r_prod <= {64'b0, r_pp[0]} + {32'b0, r_pp[1], 32'b0}
                    + {32'b0, r_pp[2], 32'b0} + {r_pp[3], 64'b0};
        end
    end

    // shift, saturate, restore sign
    assign w_sat = |r_prod[127:SH+63];
    assign w_val = w_sat ? 64'h7FFF_FFFF_FFFF_FFFF : {1'b0, r_prod[SH+62:SH]};

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p <= r_neg3 ? $signed(-w_val) : $signed(w_val);
        end
    end

    assign o_p = r_p;

endmodule

@@ rtl/geodetic_to_cartesian.sv @@
// geodetic to earth-centred cartesian converter, top level
//
//  channel   direction  handshake            payload
//  config    in         i_cfg_we             i_cfg_idx, i_cfg_data
//  point     in         i_valid / o_ready    i_latitude, i_longitude, i_height
//  position  out        o_valid / i_ready    o_x_pos, o_y_pos, o_z_pos
//
// one request accepted per cycle unless a finished result is held at the output
// the pipe holds the rotation stages, the 64-stage root and the 62-stage divider
// reset is synchronous active low and clears only valid bits and the two registers
// a held result freezes the whole pipe; nothing is dropped or duplicated
module geodetic_to_cartesian #(
    parameter int CORDIC_STEPS = g2c_pkg::CORDIC_STEPS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic               i_cfg_idx,
    input  logic [39:0]        i_cfg_data,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic signed [31:0] i_latitude,
    input  logic signed [31:0] i_longitude,
    input  logic signed [30:0] i_height,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [33:0] o_x_pos,
    output logic signed [33:0] o_y_pos,
    output logic signed [33:0] o_z_pos
);
    import g2c_pkg::*;

    // stage indexes, counted in registers after the input register
    localparam int L = MUL_LAT;
    localparam int IC = L + CORDIC_STEPS;
    localparam int ITR = IC + 1;
    localparam int ID = ITR + 2 * L + 1;
    localparam int ISQ = ID + SQRT_STEPS;
    localparam int IN = ISQ + 1 + DIV_STEPS + 1;
    localparam int IR = IN + 1;
    localparam int TE = IN + L + 1;
    localparam int IOUT = IN + 2 * L + 3;
    localparam t_q60 K_GAIN = f_gain(CORDIC_STEPS);

    logic               w_en;
    logic               r_vld [0:IOUT];
    logic [33:0]        r_axis;
    logic [39:0]        r_ecc;

    logic signed [31:0] r_ang [0:1];
    logic [1:0]         r_fl [0:IC];
    logic signed [38:0] r_hq [0:IN+L];
    t_q60               w_z0 [0:1];
    t_q60               r_cx [0:1][1:CORDIC_STEPS];
    t_q60               r_cy [0:1][1:CORDIC_STEPS];
    t_q60               r_cz [0:1][1:CORDIC_STEPS-1];
    t_trig              r_trig [ITR:TE];

    t_q60               w_s1sq, w_s1c, w_t, w_d;
    t_q60               r_sq_d [0:SQRT_STEPS-1];
    logic [63:0]        r_sq_root [1:SQRT_STEPS];
    logic [65:0]        r_sq_rem [1:SQRT_STEPS-1];

    logic [63:0]        r_dv_sd [0:DIV_STEPS-1];
    logic [63:0]        r_dv_rem [0:DIV_STEPS-1];
    logic [61:0]        r_dv_q [1:DIV_STEPS];
    logic               r_dv_ovf [0:DIV_STEPS];

    t_q60               r_n, r_r, r_mh;
    t_q60               w_u, w_m, w_res [0:2];
    logic               r_fneg [0:2];
    logic               r_fsat [0:2];
    logic [63:0]        r_fmag [0:2];
    logic signed [33:0] r_pos [0:2];

    // pipe moves unless a finished result is held; no requests during reset
    assign w_en = !r_vld[IOUT] || i_ready;
    assign o_ready = w_en && i_rst_n;
    assign o_valid = r_vld[IOUT];

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= IOUT; k++) r_vld[k] <= 1'b0;
        end else if (w_en) begin
            r_vld[0] <= i_valid;
            for (int k = 1; k <= IOUT; k++) r_vld[k] <= r_vld[k-1];
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_axis <= AXIS_RST;
            r_ecc <= ECC_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_AXIS: r_axis <= i_cfg_data[33:0];
                CFG_ECC:  r_ecc <= i_cfg_data;
                default:  r_ecc <= r_ecc;
            endcase
        end
    end

    // input stage: fold angles beyond a quarter turn by flipping the top bit
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_fl[0][0] <= (i_latitude > 32'sh4000_0000) || (i_latitude < -32'sh4000_0000);
            r_fl[0][1] <= (i_longitude > 32'sh4000_0000) || (i_longitude < -32'sh4000_0000);
            r_ang[0] <= ((i_latitude > 32'sh4000_0000) || (i_latitude < -32'sh4000_0000))
                      ? {~i_latitude[31], i_latitude[30:0]} : i_latitude;
            r_ang[1] <= ((i_longitude > 32'sh4000_0000) || (i_longitude < -32'sh4000_0000))
                      ? {~i_longitude[31], i_longitude[30:0]} : i_longitude;
            r_hq[0] <= {i_height, 8'b0};
        end
    end

    // side data delay lines
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int k = 1; k <= IC; k++) r_fl[k] <= r_fl[k-1];
            for (int k = 1; k <= IN + L; k++) r_hq[k] <= r_hq[k-1];
            for (int k = ITR + 1; k <= TE; k++) r_trig[k] <= r_trig[k-1];
        end
    end

    // angle to q60 radians, then rotation stages
    for (genvar gl = 0; gl < 2; gl++) begin : g_lane
        g2c_mul #(.SH(31)) u_ang (
            .i_clk(i_clk), .i_en(w_en),
            .i_a({{32{r_ang[gl][31]}}, r_ang[gl]}), .i_b(PI_Q60), .o_p(w_z0[gl])
        );

        for (genvar gj = 0; gj < CORDIC_STEPS; gj++) begin : g_step
            localparam t_q60 ATAN = f_atan(gj);
            t_q60 w_x, w_y, w_z;
            if (gj == 0) begin : g_first
                assign w_x = K_GAIN;
                assign w_y = '0;
                assign w_z = w_z0[gl];
            end else begin : g_next
                assign w_x = r_cx[gl][gj];
                assign w_y = r_cy[gl][gj];
                assign w_z = r_cz[gl][gj];
            end

            always_ff @(posedge i_clk) begin
                if (w_en) begin
                    if (!w_z[63]) begin
                        r_cx[gl][gj+1] <= w_x - (w_y >>> gj);
                        r_cy[gl][gj+1] <= w_y + (w_x >>> gj);
                    end else begin
                        r_cx[gl][gj+1] <= w_x + (w_y >>> gj);
                        r_cy[gl][gj+1] <= w_y - (w_x >>> gj);
                    end
                end
            end

            if (gj < CORDIC_STEPS - 1) begin : g_angle
                always_ff @(posedge i_clk) begin
                    if (w_en) begin
                        r_cz[gl][gj+1] <= w_z[63] ? w_z + ATAN : w_z - ATAN;
                    end
                end
            end
        end
    end

    // undo the fold on sine and cosine
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_trig[ITR].s1 <= r_fl[IC][0] ? -r_cy[0][CORDIC_STEPS] : r_cy[0][CORDIC_STEPS];
            r_trig[ITR].c1 <= r_fl[IC][0] ? -r_cx[0][CORDIC_STEPS] : r_cx[0][CORDIC_STEPS];
            r_trig[ITR].s2 <= r_fl[IC][1] ? -r_cy[1][CORDIC_STEPS] : r_cy[1][CORDIC_STEPS];
            r_trig[ITR].c2 <= r_fl[IC][1] ? -r_cx[1][CORDIC_STEPS] : r_cx[1][CORDIC_STEPS];
        end
    end

    // sin^2 lat, clamped to one, then e2 sin^2 lat
    g2c_mul #(.SH(60)) u_s1sq (
        .i_clk(i_clk), .i_en(w_en),
        .i_a(r_trig[ITR].s1), .i_b(r_trig[ITR].s1), .o_p(w_s1sq)
    );

    assign w_s1c = (w_s1sq > ONE_Q60) ? ONE_Q60 : w_s1sq;

    g2c_mul #(.SH(60)) u_esq (
        .i_clk(i_clk), .i_en(w_en),
        .i_a({4'b0, r_ecc, 20'b0}), .i_b(w_s1c), .o_p(w_t)
    );

    // denominator, at least one lsb
    assign w_d = ONE_Q60 - w_t;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_sq_d[0] <= (w_d < 64'sd1) ? 64'sd1 : w_d;
        end
    end

    // square root of d * 2^60, one root bit per stage
    for (genvar gk = 0; gk < SQRT_STEPS; gk++) begin : g_sqrt
        logic [127:0] w_op;
        logic [65:0]  w_rem_in;
        logic [63:0]  w_root_in;
        logic [67:0]  w_rs, w_tr;
        logic         w_ge;

        if (gk == 0) begin : g_first
            assign w_rem_in = '0;
            assign w_root_in = '0;
        end else begin : g_next
            assign w_rem_in = r_sq_rem[gk];
            assign w_root_in = r_sq_root[gk];
        end

        assign w_op = {4'b0, r_sq_d[gk], 60'b0};
        assign w_rs = {w_rem_in, w_op[127-2*gk -: 2]};
        assign w_tr = {2'b0, w_root_in, 2'b01};
        assign w_ge = w_rs >= w_tr;

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_sq_root[gk+1] <= {w_root_in[62:0], w_ge};
            end
        end

        if (gk < SQRT_STEPS - 1) begin : g_carry
            always_ff @(posedge i_clk) begin
                if (w_en) begin
                    r_sq_rem[gk+1] <= w_ge ? 66'(w_rs - w_tr) : w_rs[65:0];
                    r_sq_d[gk+1] <= r_sq_d[gk];
                end
            end
        end
    end

    // divider set-up: quotient at or above 2^62 clamps
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_dv_sd[0] <= r_sq_root[SQRT_STEPS];
            r_dv_rem[0] <= {24'b0, r_axis, 6'b0};
            r_dv_ovf[0] <= {24'b0, r_axis, 6'b0} >= r_sq_root[SQRT_STEPS];
        end
    end

    // a * 2^68 / root, one quotient bit per stage
    for (genvar gd = 0; gd < DIV_STEPS; gd++) begin : g_div
        logic [64:0] w_sh;
        logic        w_ge;
        logic [61:0] w_q_in;

        if (gd == 0) begin : g_first
            assign w_q_in = '0;
        end else begin : g_next
            assign w_q_in = r_dv_q[gd];
        end

        assign w_sh = {r_dv_rem[gd], 1'b0};
        assign w_ge = w_sh >= {1'b0, r_dv_sd[gd]};

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_dv_q[gd+1] <= {w_q_in[60:0], w_ge};
                r_dv_ovf[gd+1] <= r_dv_ovf[gd];
            end
        end

        if (gd < DIV_STEPS - 1) begin : g_carry
            always_ff @(posedge i_clk) begin
                if (w_en) begin
                    r_dv_rem[gd+1] <= w_ge ? 64'(w_sh - {1'b0, r_dv_sd[gd]}) : w_sh[63:0];
                    r_dv_sd[gd+1] <= r_dv_sd[gd];
                end
            end
        end
    end

    // radius clamp, then n + h and (1 - e2) n + h
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_n <= r_dv_ovf[DIV_STEPS] ? RADIUS_MAX : {2'b0, r_dv_q[DIV_STEPS]};
            r_r <= r_n + {{25{r_hq[IN][38]}}, r_hq[IN]};
            r_mh <= w_m + {{25{r_hq[IN+L][38]}}, r_hq[IN+L]};
        end
    end

    // (1 - e2) n
    g2c_mul #(.SH(40)) u_polar (
        .i_clk(i_clk), .i_en(w_en),
        .i_a({23'b0, 41'(41'h100_0000_0000 - {1'b0, r_ecc})}), .i_b(r_n), .o_p(w_m)
    );

    // (n + h) cos lat
    g2c_mul #(.SH(60)) u_equ (
        .i_clk(i_clk), .i_en(w_en),
        .i_a(r_r), .i_b(r_trig[IR].c1), .o_p(w_u)
    );

    g2c_mul #(.SH(60)) u_x (
        .i_clk(i_clk), .i_en(w_en),
        .i_a(w_u), .i_b(r_trig[IR+L].c2), .o_p(w_res[0])
    );

    g2c_mul #(.SH(60)) u_y (
        .i_clk(i_clk), .i_en(w_en),
        .i_a(w_u), .i_b(r_trig[IR+L].s2), .o_p(w_res[1])
    );

    g2c_mul #(.SH(60)) u_z (
        .i_clk(i_clk), .i_en(w_en),
        .i_a(r_mh), .i_b(r_trig[TE].s1), .o_p(w_res[2])
    );

    // round q8 to mm, ties away from zero, and saturate
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int c = 0; c < 3; c++) begin
                r_fneg[c] <= w_res[c][63];
                r_fmag[c] <= w_res[c][63] ? 64'(-w_res[c]) : 64'(w_res[c]);
                r_fsat[c] <= (w_res[c][63] ? 64'(-w_res[c]) : 64'(w_res[c])) >= SAT_EDGE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int c = 0; c < 3; c++) begin
                if (r_fsat[c])
                    r_pos[c] <= r_fneg[c] ? -$signed(OUT_LIMIT) : $signed(OUT_LIMIT);
                else if (r_fneg[c])
                    r_pos[c] <= -$signed(34'(r_fmag[c][41:8] + {33'b0, r_fmag[c][7]}));
                else
                    r_pos[c] <= $signed(34'(r_fmag[c][41:8] + {33'b0, r_fmag[c][7]}));
            end
        end
    end

    assign o_x_pos = r_pos[0];
    assign o_y_pos = r_pos[1];
    assign o_z_pos = r_pos[2];

    // a held result must stop new requests
    a_stall_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |-> !o_ready)
        else $error("request taken while result held");

    // outputs stay inside the saturation range
    a_out_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_x_pos <= $signed(OUT_LIMIT)) && (o_x_pos >= -$signed(OUT_LIMIT))
                 && (o_y_pos <= $signed(OUT_LIMIT)) && (o_y_pos >= -$signed(OUT_LIMIT))
                 && (o_z_pos <= $signed(OUT_LIMIT)) && (o_z_pos >= -$signed(OUT_LIMIT)))
        else $error("coordinate beyond limit");

    // denominator lies in one lsb to one
    a_den_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[ID] |-> (r_sq_d[0] >= 64'sd1) && (r_sq_d[0] <= ONE_Q60))
        else $error("denominator out of range");

    // root of at least 2^60 is at least 2^30
    a_root_floor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[ISQ] |-> r_sq_root[SQRT_STEPS] >= 64'h4000_0000)
        else $error("root below floor");

    // radius never above its clamp
    a_radius_clamp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[IN] |-> (r_n <= RADIUS_MAX) && !r_n[63])
        else $error("radius above clamp");

endmodule

@@ tb/geodetic_to_cartesian_tb.sv @@
// self-checking testbench for the geodetic to cartesian converter
`timescale 1ns / 100ps

module geodetic_to_cartesian_tb;
    import g2c_pkg::*;

    localparam int STEPS = CORDIC_STEPS_DEF;
    localparam int LATENCY = STEPS + 153;
    localparam int HOLD_CYCLES = 500;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam logic [63:0] INT64_TOP = 64'h7FFF_FFFF_FFFF_FFFF;

    typedef struct packed {
        logic [33:0] x;
        logic [33:0] y;
        logic [33:0] z;
    } t_pos;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic i_cfg_idx;
    logic [39:0] i_cfg_data;
    logic i_valid;
    logic o_ready;
    logic signed [31:0] i_latitude;
    logic signed [31:0] i_longitude;
    logic signed [30:0] i_height;
    logic o_valid;
    logic i_ready;
    logic signed [33:0] o_x_pos;
    logic signed [33:0] o_y_pos;
    logic signed [33:0] o_z_pos;

    geodetic_to_cartesian DUT (.*);

    // clock
    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // predictor state: rotation tables and register copies
    t_q60 atan_tab [STEPS];
    t_q60 rot_gain;
    logic [33:0] axis_mm;
    logic [39:0] ecc_frac;

    t_pos expected_pos [$];
    int errors = 0;
    int points_sent = 0;
    int positions_checked = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    logic recv_hold = 1'b0;
    event hold_start;

    // product shifted right, truncated toward zero, saturated at int64 max
    function automatic t_q60 prod_shift(input t_q60 a, input t_q60 b, input int sh);
        logic [63:0] ua;
        logic [63:0] ub;
        logic [127:0] p;
        logic neg;
        neg = a[63] ^ b[63];
        ua = a[63] ? 64'(0) - a : a;
        ub = b[63] ? 64'(0) - b : b;
        p = ({64'b0, ua} * {64'b0, ub}) >> sh;
        if (p > {64'b0, INT64_TOP})
            p = {64'b0, INT64_TOP};
        return neg ? -$signed(p[63:0]) : $signed(p[63:0]);
    endfunction

    function automatic logic [63:0] isqrt(input logic [127:0] v);
        logic [63:0] r;
        logic [63:0] t;
        r = '0;
        for (int b = 63; b >= 0; b--) begin
            t = r | (64'(1) << b);
            if ({64'b0, t} * {64'b0, t} <= v)
                r = t;
        end
        return r;
    endfunction

    // sine and cosine of an angle in pi/2^31 units
    function automatic void rotate(input logic signed [31:0] ang, output t_q60 s,
                                   output t_q60 c);
        longint a;
        logic flip;
        t_q60 x;
        t_q60 y;
        t_q60 z;
        t_q60 nx;
        a = longint'(ang);
        flip = 1'b0;
        if (a > (64'sd1 <<< 30)) begin
            a = a - (64'sd1 <<< 31);
            flip = 1'b1;
        end else if (a < -(64'sd1 <<< 30)) begin
            a = a + (64'sd1 <<< 31);
            flip = 1'b1;
        end
        z = prod_shift(a, PI_Q60, 31);
        x = rot_gain;
        y = '0;
        for (int i = 0; i < STEPS; i++) begin
            if (z >= 0) begin
                nx = x - (y >>> i);
                y = y + (x >>> i);
                z = z - atan_tab[i];
            end else begin
                nx = x + (y >>> i);
                y = y - (x >>> i);
                z = z + atan_tab[i];
            end
            x = nx;
        end
        s = flip ? -y : y;
        c = flip ? -x : x;
    endfunction

    // q8 millimetres to whole millimetres, ties away from zero, saturated
    function automatic logic [33:0] round_mm(input t_q60 v);
        logic [63:0] mag;
        t_q60 r;
        mag = v[63] ? 64'(0) - v : v;
        mag = (mag >> 8) + ((mag >> 7) & 64'd1);
        if (mag > 64'(OUT_LIMIT))
            mag = 64'(OUT_LIMIT);
        r = v[63] ? -$signed(mag) : $signed(mag);
        return r[33:0];
    endfunction

    function automatic t_pos geodetic_to_ecef(input logic signed [31:0] lat,
                                              input logic signed [31:0] lon,
                                              input logic signed [30:0] h);
        t_q60 s1, c1, s2, c2, hq, s1sq, t, d, n, r, u, m;
        logic [63:0] sd;
        logic [127:0] q;
        t_pos p;
        rotate(lat, s1, c1);
        rotate(lon, s2, c2);
        hq = longint'(h) * 256;
        s1sq = prod_shift(s1, s1, 60);
        if (s1sq > ONE_Q60)
            s1sq = ONE_Q60;
        t = prod_shift({24'b0, ecc_frac} << 20, s1sq, 60);
        d = ONE_Q60 - t;
        if (d < 1)
            d = 1;
        sd = isqrt({64'b0, d} << 60);
        q = ({94'b0, axis_mm} << 68) / {64'b0, sd};
        if (q > {64'b0, RADIUS_MAX})
            q = {64'b0, RADIUS_MAX};
        n = $signed(q[63:0]);
        r = n + hq;
        u = prod_shift(r, c1, 60);
        p.x = round_mm(prod_shift(u, c2, 60));
        p.y = round_mm(prod_shift(u, s2, 60));
        m = prod_shift((64'(1) << 40) - {24'b0, ecc_frac}, n, 40);
        p.z = round_mm(prod_shift(m + hq, s1, 60));
        return p;
    endfunction

    // rotation tables, built once
    initial begin
        logic [63:0] p;
        t_q60 sum;
        int e;
        atan_tab[0] = PI_Q60 >>> 2;
        for (int i = 1; i < STEPS; i++) begin
            sum = '0;
            for (int k = 0; 60 - i * (2 * k + 1) >= 0; k++) begin
                e = 60 - i * (2 * k + 1);
                if (k % 2 == 1)
                    sum = sum - $signed((64'(1) << e) / 64'(2 * k + 1));
                else
                    sum = sum + $signed((64'(1) << e) / 64'(2 * k + 1));
            end
            atan_tab[i] = sum;
        end
        p = 64'(1) << 60;
        for (int i = 0; i < STEPS; i++)
            if (2 * i < 64)
                p = p + (p >> (2 * i));
        rot_gain = $signed(64'(((128'(1) << 120) / {64'b0, isqrt({64'b0, p} << 60)})));
    end

    // accepted requests get their expected position
    always @(posedge i_clk) begin
        if (i_rst_n && i_valid && o_ready) begin
            expected_pos.push_back(geodetic_to_ecef(i_latitude, i_longitude, i_height));
            points_sent++;
        end
    end

    // position checker
    always @(posedge i_clk) begin
        t_pos e;
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_pos.size() == 0) begin
                $display("%0t: unexpected position x=%0d y=%0d z=%0d", $time,
                         o_x_pos, o_y_pos, o_z_pos);
                errors++;
            end else begin
                e = expected_pos.pop_front();
                positions_checked++;
                if (o_x_pos !== e.x) begin
                    $display("%0t: x mismatch expected %0d actual %0d", $time,
                             $signed(e.x), o_x_pos);
                    errors++;
                end
                if (o_y_pos !== e.y) begin
                    $display("%0t: y mismatch expected %0d actual %0d", $time,
                             $signed(e.y), o_y_pos);
                    errors++;
                end
                if (o_z_pos !== e.z) begin
                    $display("%0t: z mismatch expected %0d actual %0d", $time,
                             $signed(e.z), o_z_pos);
                    errors++;
                end
            end
        end
    end

    // receiver stalls
    always @(negedge i_clk) begin
        i_ready <= !recv_hold && ($urandom_range(99) >= recv_stall_pct);
    end

    // long hold-off of the receiver
    always begin
        @(hold_start);
        recv_hold = 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        recv_hold = 1'b0;
    end

    // watchdog on cycles with no handshake
    always @(posedge i_clk) begin
        int quiet;
        if ((i_valid && o_ready) || (o_valid && i_ready))
            quiet = 0;
        else
            quiet++;
        if (quiet >= WATCHDOG_LIMIT) begin
            $display("watchdog expired, %0d positions outstanding", expected_pos.size());
            $display("geodetic_to_cartesian verification failed");
            $finish;
        end
    end

    // one request; called and returns at a falling edge
    task automatic send_point(input logic signed [31:0] lat, input logic signed [31:0] lon,
                              input logic signed [30:0] h);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_latitude <= lat;
        i_longitude <= lon;
        i_height <= h;
        do @(posedge i_clk); while (!o_ready);
        @(negedge i_clk);
    endtask

    // wait until every position is back and the pipe is empty
    task automatic drain();
        i_valid <= 1'b0;
        while (expected_pos.size() != 0)
            @(negedge i_clk);
        repeat (LATENCY + 10) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic [39:0] value);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= value;
        if (idx == CFG_AXIS)
            axis_mm = value[33:0];
        else
            ecc_frac = value;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic random_point();
        logic signed [31:0] lat;
        logic signed [30:0] h;
        if ($urandom_range(15) == 0)
            lat = $urandom;
        else
            lat = 32'(longint'($urandom_range(0, 32'h8000_0000)) - 64'sh4000_0000);
        case ($urandom_range(9))
            0: h = -31'sd10000000;
            1: h = 31'sd1000000000;
            2: h = 31'(longint'($urandom_range(0, 20000)) - 10000);
            default: h = 31'(longint'($urandom_range(0, 1010000000)) - 10000000);
        endcase
        send_point(lat, $urandom, h);
    endtask

    // extremes and special angles under the default ellipsoid
    task automatic test_directed();
        send_point(0, 0, 0);
        send_point(32'sh4000_0000, 0, 0);
        send_point(-32'sh4000_0000, 32'sh2000_0000, 0);
        send_point(32'sh2000_0000, 32'sh7FFF_FFFF, 31'sd1000000000);
        send_point(-32'sh2000_0000, 32'sh8000_0000, -31'sd10000000);
        send_point(0, 32'sh4000_0000, 31'sd1000000000);
        send_point(0, -32'sh4000_0000, -31'sd10000000);
        send_point(32'sh4000_0001, 32'sh4000_0001, 5);
        send_point(32'sh7FFF_FFFF, 0, 1);
        send_point(32'sh8000_0000, 32'sh1234_5678, -1);
        send_point(32'shC000_0000, -32'sh4000_0001, 31'sh3FFF_FFFF);
        send_point(32'sh1555_5555, 32'shAAAA_AAAA, -31'sh4000_0000);
        send_point(-1, -1, 128);
        drain();
    endtask

    // each ellipsoid setting with a few points, extremes included
    task automatic test_config_sweep();
        logic [39:0] axes [5];
        logic [39:0] eccs [5];
        axes = '{40'd1, 40'd10000000000, 40'd0, 40'd6378137000, 40'(34'h3_FFFF_FFFF)};
        eccs = '{40'd0, 40'hFF_FFFF_FFFF, 40'd7360548640, 40'h80_0000_0000, 40'h55_5555_5555};
        for (int s = 0; s < 5; s++) begin
            write_reg(CFG_AXIS, axes[s]);
            write_reg(CFG_ECC, eccs[s]);
            send_point(32'sh4000_0000, 0, 31'sd1000000000);
            send_point(0, 32'sh8000_0000, -31'sd10000000);
            repeat (18) random_point();
            drain();
        end
        write_reg(CFG_AXIS, 40'(AXIS_RST));
        write_reg(CFG_ECC, 40'(ECC_RST));
        write_reg(CFG_AXIS, 40'({$urandom_range(0, 255), $urandom} % 64'd10000000001));
        write_reg(CFG_ECC, 40'({$urandom_range(0, 255), $urandom}));
        repeat (20) random_point();
        drain();
        write_reg(CFG_AXIS, 40'(AXIS_RST));
        write_reg(CFG_ECC, 40'(ECC_RST));
    endtask

    task automatic test_random(input int count, input int idle_pct, input int stall_pct);
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        repeat (count) random_point();
        drain();
    endtask

    // receiver holds off while requests keep coming, so the pipe fills
    task automatic test_backpressure();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        -> hold_start;
        repeat (300) random_point();
        drain();
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = CFG_AXIS;
        i_cfg_data = '0;
        i_valid = 1'b0;
        i_latitude = '0;
        i_longitude = '0;
        i_height = '0;
        axis_mm = AXIS_RST;
        ecc_frac = ECC_RST;
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_directed();
        test_config_sweep();
        test_random(350, 0, 0);
        test_random(350, 66, 0);
        test_random(350, 0, 66);
        test_random(350, 32, 32);
        test_backpressure();

        $display("covered %0d points under 7 ellipsoid settings, %0d positions checked,",
                 points_sent, positions_checked);
        $display("with sender gaps, receiver stalls and one long receiver hold-off");
        if (errors == 0)
            $display("geodetic_to_cartesian verification clean");
        else
            $display("geodetic_to_cartesian verification failed");
        $finish;
    end

endmodule
